// ===== rtl/gcns_pkg.sv =====
// Shared types and constants for the grid cell neighbor stencil.
// Used by every module of the block but the queue, and by its checker; depends on nothing.
package gcns_pkg;

   // Width of one axis register as written through the register port.
   localparam int CFG_BITS   = 9;
   localparam int PLANE_BITS = 2 * CFG_BITS;
   localparam int TOTAL_BITS = 3 * CFG_BITS;
   // Signed offset from the center cell to a neighbor: +-(1 + cells_x + plane).
   localparam int DELTA_BITS = PLANE_BITS + 2;

   // Result payload widths.
   localparam int NB_BITS  = 25;
   localparam int POS_BITS = 5;

   localparam logic signed [NB_BITS-1:0] NO_CELL = '1;

   // Last stencil position for each mode.
   localparam logic [POS_BITS-1:0] LAST_POS_2D = 5'd8;
   localparam logic [POS_BITS-1:0] LAST_POS_3D = 5'd26;

   // Register indexes on the register port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CELLS_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CELLS_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CELLS_Z = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THREE_D = 2'd3;

   // Offset codes for one axis of the stencil walk.
   localparam logic [1:0] OFS_NEG  = 2'd0;
   localparam logic [1:0] OFS_ZERO = 2'd1;
   localparam logic [1:0] OFS_POS  = 2'd2;

   // Effective grid configuration, with derived plane and cell counts.
   typedef struct packed {
      logic [CFG_BITS-1:0]   cells_x;
      logic [CFG_BITS-1:0]   cells_y;
      logic [CFG_BITS-1:0]   cells_z;
      logic                  three_d;
      logic [PLANE_BITS-1:0] plane;
      logic [TOTAL_BITS-1:0] total;
   } cfg_type;

endpackage

// ===== rtl/gcns_front.sv =====
// Front end of the stencil block: request slot, coordinate recovery and classification.
// Uses gcns_pkg for the configuration type; feeds gcns_queue.
module gcns_front #(
   parameter int INDEX_BITS     = 24,
   parameter int MAX_AXIS_CELLS = 256,
   localparam int AXIS_BITS     = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1,
   localparam int ENTRY_BITS    = INDEX_BITS + 3 * AXIS_BITS + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [INDEX_BITS-1:0]   req_index,
   output logic                    busy,
   input  gcns_pkg::cfg_type       cfg,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [ENTRY_BITS-1:0]   q_data
);

   localparam int STEPS    = (INDEX_BITS + 1) / 2;
   localparam int DW       = 2 * STEPS;
   localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(STEPS - 1);
   localparam int CB       = gcns_pkg::CFG_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVX = 2'd1;
   localparam logic [1:0] ST_DIVY = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [INDEX_BITS-1:0] pend_index_ff, pend_index_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]         quo_ff, quo_in;
   logic [CB-1:0]         rem_ff, rem_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [AXIS_BITS-1:0]  x_ff, x_in;

   logic [CB-1:0]         divisor;
   logic [CB-1:0]         shift1, shift2, r1, r2;
   logic                  ge1, ge2;
   logic [DW-1:0]         quo_step;
   logic                  bad;

   // Two restoring division steps per cycle; the divisor is at most 256,
   // so the partial remainder always fits the register width.
   always_comb begin
      divisor  = (state_ff == ST_DIVX) ? cfg.cells_x : cfg.cells_y;
      shift1   = {rem_ff[CB-2:0], quo_ff[DW-1]};
      ge1      = (shift1 >= divisor);
      r1       = ge1 ? (shift1 - divisor) : shift1;
      shift2   = {r1[CB-2:0], quo_ff[DW-2]};
      ge2      = (shift2 >= divisor);
      r2       = ge2 ? (shift2 - divisor) : shift2;
      quo_step = DW'({quo_ff, ge1, ge2});
   end

   // An index at or past the cell count is flagged for the back end.
   assign bad    = ({{(gcns_pkg::TOTAL_BITS - INDEX_BITS){1'b0}}, idx_ff} >= cfg.total);
   assign busy   = pend_valid_ff;
   assign q_push = (state_ff == ST_PUSH) && !q_full;
   // After the second pass the remainder is y and the quotient is z.
   assign q_data = {idx_ff, x_ff, AXIS_BITS'(rem_ff), AXIS_BITS'(quo_ff), bad};

   // Request slot: one transfer is held while the divider works on the previous one.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      if ((state_ff == ST_IDLE) && pend_valid_ff) begin
         pend_valid_in = 1'b0;
      end
      if (start && !pend_valid_ff) begin
         pend_valid_in = 1'b1;
         pend_index_in = req_index;
      end
   end

   // Sequencer: x from index / cells_x, then y and z from the quotient / cells_y.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pend_valid_ff) begin
               quo_in   = DW'(pend_index_ff);
               idx_in   = pend_index_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            quo_in = quo_step;
            rem_in = r2;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               x_in     = AXIS_BITS'(r2);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            quo_in = quo_step;
            rem_in = r2;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      pend_index_ff <= pend_index_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      x_ff          <= x_in;
   end

endmodule

// ===== rtl/gcns_queue.sv =====
// Two-entry queue that decouples the front end from the stencil walker.
// Generic payload vector; depends on nothing else.
module gcns_queue #(
   parameter int DATA_BITS = 49
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 empty,
   output logic                 full
);

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update for each transfer in and out.
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/gcns_back.sv =====
// Back end of the stencil block: walks the 3x3 or 3x3x3 stencil of one queued cell.
// Uses gcns_pkg for the configuration type and result constants; fed by gcns_queue.
module gcns_back #(
   parameter int INDEX_BITS     = 24,
   parameter int MAX_AXIS_CELLS = 256,
   localparam int AXIS_BITS     = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1,
   localparam int ENTRY_BITS    = INDEX_BITS + 3 * AXIS_BITS + 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gcns_pkg::cfg_type                      cfg,
   input  logic                                   q_empty,
   input  logic [ENTRY_BITS-1:0]                  q_data,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   output logic signed [gcns_pkg::NB_BITS-1:0]    rsp_neighbor_index,
   output logic [gcns_pkg::POS_BITS-1:0]          rsp_stencil_position,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_index
);

   localparam int CB = gcns_pkg::CFG_BITS;
   localparam int DB = gcns_pkg::DELTA_BITS;
   localparam int NB = gcns_pkg::NB_BITS;
   localparam int PB = gcns_pkg::POS_BITS;

   // Queue entry fields.
   logic [INDEX_BITS-1:0] e_idx;
   logic [AXIS_BITS-1:0]  e_x, e_y, e_z;
   logic                  e_bad;

   // Walker state for the cell being expanded.
   logic                  act_ff, act_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [AXIS_BITS-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                  bad_ff, bad_in;
   logic [1:0]            dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [PB-1:0]         pos_ff, pos_in;

   // Offset stage.
   logic                  stg_valid_ff;
   logic [INDEX_BITS-1:0] stg_idx_ff;
   logic signed [DB-1:0]  stg_delta_ff;
   logic                  stg_ok_ff;
   logic [PB-1:0]         stg_pos_ff;
   logic                  stg_last_ff;
   logic                  stg_bad_ff;

   // Result registers.
   logic                  rsp_valid_ff;
   logic signed [NB-1:0]  rsp_nb_ff;
   logic [PB-1:0]         rsp_pos_ff;
   logic                  rsp_last_ff;
   logic                  rsp_bad_ff;

   logic [PB-1:0]         last_pos;
   logic                  at_last;
   logic                  take;
   logic [1:0]            dz_first;
   logic                  dz_end;
   logic [CB-1:0]         x_ext, y_ext, z_ext;
   logic                  x_ok, y_ok, z_ok, cell_ok;
   logic signed [DB-1:0]  dx_term, dy_term, dz_term, delta;
   logic [NB-1:0]         nb_sum;

   assign {e_idx, e_x, e_y, e_z, e_bad} = q_data;

   assign last_pos = cfg.three_d ? gcns_pkg::LAST_POS_3D : gcns_pkg::LAST_POS_2D;
   assign at_last  = act_ff && (pos_ff == last_pos);
   assign take     = !q_empty && (!act_ff || at_last);
   assign q_pop    = take;
   assign dz_first = cfg.three_d ? gcns_pkg::OFS_NEG : gcns_pkg::OFS_ZERO;
   assign dz_end   = !cfg.three_d || (dz_ff == gcns_pkg::OFS_POS);

   // Walk order: x offset outermost, then y, then z innermost.
   always_comb begin
      act_in = act_ff;
      idx_in = idx_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      bad_in = bad_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      dz_in  = dz_ff;
      pos_in = pos_ff;
      if (take) begin
         act_in = 1'b1;
         idx_in = e_idx;
         x_in   = e_x;
         y_in   = e_y;
         z_in   = e_z;
         bad_in = e_bad;
         dx_in  = gcns_pkg::OFS_NEG;
         dy_in  = gcns_pkg::OFS_NEG;
         dz_in  = dz_first;
         pos_in = '0;
      end else if (at_last) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         pos_in = pos_ff + PB'(1);
         if (dz_end) begin
            dz_in = dz_first;
            if (dy_ff == gcns_pkg::OFS_POS) begin
               dy_in = gcns_pkg::OFS_NEG;
               dx_in = dx_ff + 2'd1;
            end else begin
               dy_in = dy_ff + 2'd1;
            end
         end else begin
            dz_in = dz_ff + 2'd1;
         end
      end
   end

   // Boundary checks: a step below zero or past the last cell leaves the grid.
   always_comb begin
      x_ext = {{(CB - AXIS_BITS){1'b0}}, x_ff};
      y_ext = {{(CB - AXIS_BITS){1'b0}}, y_ff};
      z_ext = {{(CB - AXIS_BITS){1'b0}}, z_ff};
      x_ok  = !((dx_ff == gcns_pkg::OFS_NEG) && (x_ext == '0)) &&
              !((dx_ff == gcns_pkg::OFS_POS) && (x_ext == cfg.cells_x - CB'(1)));
      y_ok  = !((dy_ff == gcns_pkg::OFS_NEG) && (y_ext == '0)) &&
              !((dy_ff == gcns_pkg::OFS_POS) && (y_ext == cfg.cells_y - CB'(1)));
      z_ok  = !((dz_ff == gcns_pkg::OFS_NEG) && (z_ext == '0)) &&
              !((dz_ff == gcns_pkg::OFS_POS) && (z_ext == cfg.cells_z - CB'(1)));
      cell_ok = !bad_ff && x_ok && y_ok && z_ok;
   end

   // Linear offset of the neighbor: dx + dy * cells_x + dz * plane.
   always_comb begin
      dx_term = '0;
      dy_term = '0;
      dz_term = '0;
      case (dx_ff)
         gcns_pkg::OFS_NEG: dx_term = -DB'(1);
         gcns_pkg::OFS_POS: dx_term = DB'(1);
         default:           dx_term = '0;
      endcase
      case (dy_ff)
         gcns_pkg::OFS_NEG: dy_term = -$signed({{(DB - CB){1'b0}}, cfg.cells_x});
         gcns_pkg::OFS_POS: dy_term = $signed({{(DB - CB){1'b0}}, cfg.cells_x});
         default:           dy_term = '0;
      endcase
      case (dz_ff)
         gcns_pkg::OFS_NEG: dz_term = -$signed({2'b00, cfg.plane});
         gcns_pkg::OFS_POS: dz_term = $signed({2'b00, cfg.plane});
         default:           dz_term = '0;
      endcase
      delta = dx_term + dy_term + dz_term;
   end

   // The center index plus the sign-extended offset, modulo the result width.
   assign nb_sum = {{(NB - INDEX_BITS){1'b0}}, stg_idx_ff} +
                   {{(NB - DB){stg_delta_ff[DB-1]}}, stg_delta_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_neighbor_index   = rsp_nb_ff;
   assign rsp_stencil_position = rsp_pos_ff;
   assign rsp_last             = rsp_last_ff;
   assign rsp_bad_index        = rsp_bad_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         stg_valid_ff <= act_ff;
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   // Walker, offset stage and result registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      bad_ff       <= bad_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      pos_ff       <= pos_in;
      stg_idx_ff   <= idx_ff;
      stg_delta_ff <= delta;
      stg_ok_ff    <= cell_ok;
      stg_pos_ff   <= pos_ff;
      stg_last_ff  <= at_last;
      stg_bad_ff   <= bad_ff;
      rsp_nb_ff    <= stg_ok_ff ? $signed(nb_sum) : gcns_pkg::NO_CELL;
      rsp_pos_ff   <= stg_pos_ff;
      rsp_last_ff  <= stg_last_ff;
      rsp_bad_ff   <= stg_bad_ff;
   end

endmodule

// ===== rtl/grid_cell_neighbor_stencil.sv =====
// Top level of the grid cell neighbor stencil: register file and block wiring.
// Depends on gcns_pkg, gcns_front, gcns_queue and gcns_back.

// A request carries the linear index of one cell and is taken while busy is low;
// one more request is held while the previous one is still being decoded. The
// front end recovers x, y and z with a shared radix-4 divider, one pass for
// index / cells_x and one for that quotient / cells_y. The back end then sends
// 9 (2D) or 27 (3D) results on consecutive cycles, one per stencil position, with
// rsp_last on the final one; the walk of one request overlaps the decoding of the
// next. Results cannot be held off; rsp_valid marks each one for a single cycle.
// Register writes are always ready and must be made only while no request is
// outstanding.
module grid_cell_neighbor_stencil #(
   parameter int MAX_AXIS_CELLS = 256,
   parameter int INDEX_BITS     = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [INDEX_BITS-1:0]                     req_cell_index,
   output logic                                      rsp_valid,
   output logic signed [gcns_pkg::NB_BITS-1:0]       rsp_neighbor_index,
   output logic [gcns_pkg::POS_BITS-1:0]             rsp_stencil_position,
   output logic                                      rsp_last,
   output logic                                      rsp_bad_index,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [gcns_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [gcns_pkg::CFG_BITS-1:0]             csr_data
);

   localparam int AXIS_BITS  = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1;
   localparam int ENTRY_BITS = INDEX_BITS + 3 * AXIS_BITS + 1;
   localparam int CB         = gcns_pkg::CFG_BITS;
   localparam logic [CB-1:0] AXIS_MAX = CB'(MAX_AXIS_CELLS);

   logic [CB-1:0]     cells_x_ff, cells_x_in;
   logic [CB-1:0]     cells_y_ff, cells_y_in;
   logic [CB-1:0]     cells_z_ff, cells_z_in;
   logic              three_d_ff, three_d_in;
   gcns_pkg::cfg_type cfg_ff, cfg_in;

   logic                  q_push, q_pop, q_empty, q_full;
   logic [ENTRY_BITS-1:0] q_push_data, q_pop_data;

   // Zero acts as one cell and anything past the limit as the limit.
   function automatic logic [CB-1:0] axis_eff(input logic [CB-1:0] v);
      logic [CB-1:0] r;
      r = v;
      if (v == '0) begin
         r = CB'(1);
      end else if (v > AXIS_MAX) begin
         r = AXIS_MAX;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      cells_x_in = cells_x_ff;
      cells_y_in = cells_y_ff;
      cells_z_in = cells_z_ff;
      three_d_in = three_d_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gcns_pkg::REG_CELLS_X: cells_x_in = csr_data;
            gcns_pkg::REG_CELLS_Y: cells_y_in = csr_data;
            gcns_pkg::REG_CELLS_Z: cells_z_in = csr_data;
            gcns_pkg::REG_THREE_D: three_d_in = csr_data[0];
            default:               three_d_in = three_d_ff;
         endcase
      end
   end

   // Effective configuration; plane is registered from the registered axis counts,
   // and total is registered from the registered plane.
   always_comb begin
      cfg_in.cells_x = axis_eff(cells_x_ff);
      cfg_in.cells_y = axis_eff(cells_y_ff);
      cfg_in.cells_z = three_d_ff ? axis_eff(cells_z_ff) : CB'(1);
      cfg_in.three_d = three_d_ff;
      cfg_in.plane   = gcns_pkg::PLANE_BITS'(cfg_ff.cells_x) *
                       gcns_pkg::PLANE_BITS'(cfg_ff.cells_y);
      cfg_in.total   = gcns_pkg::TOTAL_BITS'(cfg_ff.plane) *
                       gcns_pkg::TOTAL_BITS'(cfg_ff.cells_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CB'(1);
         cells_y_ff <= CB'(1);
         cells_z_ff <= CB'(1);
         three_d_ff <= 1'b1;
      end else begin
         cells_x_ff <= cells_x_in;
         cells_y_ff <= cells_y_in;
         cells_z_ff <= cells_z_in;
         three_d_ff <= three_d_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   gcns_front #(
      .INDEX_BITS     (INDEX_BITS),
      .MAX_AXIS_CELLS (MAX_AXIS_CELLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_index (req_cell_index),
      .busy      (busy),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   gcns_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   gcns_back #(
      .INDEX_BITS     (INDEX_BITS),
      .MAX_AXIS_CELLS (MAX_AXIS_CELLS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_empty              (q_empty),
      .q_data               (q_pop_data),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_neighbor_index   (rsp_neighbor_index),
      .rsp_stencil_position (rsp_stencil_position),
      .rsp_last             (rsp_last),
      .rsp_bad_index        (rsp_bad_index)
   );

endmodule

// ===== rtl/gcns_checker.sv =====
// Port-level checks for the grid cell neighbor stencil, bound to its top level.
// Depends on gcns_pkg for result widths and stencil constants.
module gcns_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [gcns_pkg::NB_BITS-1:0] rsp_neighbor_index,
   input logic [gcns_pkg::POS_BITS-1:0]       rsp_stencil_position,
   input logic                                rsp_last,
   input logic                                rsp_bad_index
);

   // A request transfer fills the holding slot.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request transfer");

   // The final result sits at the end of a 9 or 27 cell stencil.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_stencil_position == gcns_pkg::LAST_POS_2D) ||
         (rsp_stencil_position == gcns_pkg::LAST_POS_3D))
      else $error("last result at an unexpected stencil position");

   // Results of one request come on consecutive cycles in walk order.
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_valid && (rsp_stencil_position == $past(rsp_stencil_position) + 5'd1))
      else $error("stencil walk broken or out of order");

   // A new request starts its walk at position zero.
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid || (rsp_stencil_position == '0))
      else $error("stencil walk did not restart at position zero");

   // A bad request yields no neighbor at all.
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_neighbor_index == gcns_pkg::NO_CELL)
      else $error("neighbor reported for an index outside the grid");

endmodule

bind grid_cell_neighbor_stencil gcns_checker u_gcns_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_neighbor_index   (rsp_neighbor_index),
   .rsp_stencil_position (rsp_stencil_position),
   .rsp_last             (rsp_last),
   .rsp_bad_index        (rsp_bad_index)
);
